### rtl/ffl_pkg.sv
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared constants, codes and types of the first-fit increasing lane splitter.
// ----------------------------------------------------------------------------
package ffl_pkg;

  localparam int LANES      = 8;
  localparam int LANE_DEPTH = 256;
  localparam int ADDR_W     = (LANE_DEPTH > 2) ? $clog2(LANE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LANE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PLACE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    ST_PLACED  = 3'd0,
    ST_FAIL    = 3'd1,
    ST_FULL    = 3'd2,
    ST_READ_OK = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  // command broadcast to every lane cell for one cycle
  typedef struct packed {
    logic               place;
    logic               rd;
    logic               clr;
    logic signed [31:0] value;
    logic [ADDR_W-1:0]  addr;
  } cell_cmd_t;

  // what a lane cell reports back
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic               full;
    logic signed [31:0] rdata;
  } cell_stat_t;

endpackage

### rtl/ffl_in_if.sv
// ----------------------------------------------------------------------------
// ffl_in_if
// Input word channel: action, value, lane and position with valid/ready.
// ----------------------------------------------------------------------------
interface ffl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;
  logic [2:0]         lane;
  logic [7:0]         position;

  modport source (output valid, action, value, lane, position, input ready);
  modport sink   (input valid, action, value, lane, position, output ready);
endinterface

### rtl/ffl_out_if.sv
// ----------------------------------------------------------------------------
// ffl_out_if
// Result word channel: status, chosen lane, read value and lane length.
// ----------------------------------------------------------------------------
interface ffl_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [2:0]         chosen_lane;
  logic signed [31:0] read_value;
  logic [8:0]         lane_length;

  modport source (output valid, status, chosen_lane, read_value, lane_length,
                  input ready);
  modport sink   (input valid, status, chosen_lane, read_value, lane_length,
                  output ready);
endinterface

### rtl/ffl_cfg_if.sv
// ----------------------------------------------------------------------------
// ffl_cfg_if
// Configuration write channel carrying the lanes_in_use register word.
// ----------------------------------------------------------------------------
interface ffl_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/ffl_cell.sv
// ----------------------------------------------------------------------------
// ffl_cell
// One lane: tail value, entry count and the lane's entry memory. Takes the
// first-fit claim from its left neighbor and passes it on to the right.
// ----------------------------------------------------------------------------
module ffl_cell
  import ffl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  logic       active_i,
  input  logic       rd_sel_i,
  input  logic       hit_i,
  output logic       hit_o,
  output logic       sel_o,
  output cell_stat_t stat_o
);

  logic signed [31:0] tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [31:0] rdata_q;
  logic signed [31:0] mem [LANE_DEPTH];
  logic               fit;
  logic               full;
  logic               we;

  assign fit   = active_i && (cmd_i.value > tail_q);
  assign sel_o = fit && !hit_i;
  assign hit_o = hit_i || fit;
  assign full  = (count_q == CNT_W'(LANE_DEPTH));
  assign we    = cmd_i.place && sel_o && !full;

  always_comb begin
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.clr) begin
      tail_d  = -32'sd1;
      count_d = '0;
    end else if (we) begin
      tail_d  = cmd_i.value;
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q  <= -32'sd1;
      count_q <= '0;
    end else begin
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[count_q[ADDR_W-1:0]] <= cmd_i.value;
    end
    if (cmd_i.rd && rd_sel_i) begin
      rdata_q <= mem[cmd_i.addr];
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.full  = full;
  assign stat_o.rdata = rdata_q;

endmodule

### rtl/first_fit_increasing_lanes.sv
// ----------------------------------------------------------------------------
// first_fit_increasing_lanes
// Splits a stream of signed values into increasing lanes by first fit.
// ----------------------------------------------------------------------------
// Each input word moves through capture, in which the word is registered,
// execute, in which the row of lane cells compares all tails at once and
// updates (or starts the registered read of the addressed lane memory), and
// done, in which the result is assembled into the output register. A new word
// is accepted in the done state when the output register is free, so the
// block takes the next word while the last result is being loaded, but not
// while a word is in execute; the registered read port of the per-lane entry
// memories sets this. Entry memories are not cleared at reset or by a clear
// action; only entries below a lane's count are ever returned.
module first_fit_increasing_lanes
  import ffl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ffl_in_if.sink       in_i,
  ffl_out_if.source    out_o,
  ffl_cfg_if.sink      cfg_i
);

  state_e             state_q, state_d;
  logic [3:0]         lanes_q;
  logic               failed_q, failed_d;
  logic [1:0]         act_q;
  logic signed [31:0] value_q;
  logic [2:0]         lane_q;
  logic [7:0]         pos_q;

  logic [2:0]         res_status_q, res_status_d;
  logic [2:0]         res_lane_q, res_lane_d;
  logic [8:0]         res_len_q, res_len_d;
  logic               res_rd_q, res_rd_d;

  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic [2:0]         out_lane_q;
  logic signed [31:0] out_value_q;
  logic [8:0]         out_len_q;

  logic               in_fire;
  logic               out_free;
  logic               load_out;
  logic               exec;

  cell_cmd_t          cmd;
  logic [LANES-1:0]   active;
  logic [LANES-1:0]   rd_sel;
  logic [LANES-1:0]   sel;
  logic [LANES:0]     hit;
  cell_stat_t         stat [LANES];

  logic [2:0]         pick_lane;
  logic [CNT_W-1:0]   pick_count;
  logic               pick_full;
  logic [CNT_W-1:0]   rd_count;
  logic signed [31:0] rd_data;

  // ---------------------------------------------------------------- control
  assign out_free = !out_valid_q || out_o.ready;
  assign exec     = (state_q == S_EXEC);

  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE: in_i.ready = 1'b1;
      S_DONE: begin
        in_i.ready = out_free;
        load_out   = out_free;
      end
      default: ;
    endcase
  end

  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_EXEC;
      S_EXEC: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = in_fire ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lanes_q  <= 4'd8;
      failed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      failed_q <= failed_d;
      if (cfg_i.valid) begin
        lanes_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= in_i.action;
      value_q <= in_i.value;
      lane_q  <= in_i.lane;
      pos_q   <= in_i.position;
    end
    if (exec) begin
      res_status_q <= res_status_d;
      res_lane_q   <= res_lane_d;
      res_len_q    <= res_len_d;
      res_rd_q     <= res_rd_d;
    end
  end

  // --------------------------------------------------------------- lane row
  always_comb begin
    cmd.place = exec && (act_q == ACT_PLACE) && !failed_q;
    cmd.rd    = exec && (act_q == ACT_READ);
    cmd.clr   = exec && (act_q == ACT_CLEAR);
    cmd.value = value_q;
    cmd.addr  = ADDR_W'(pos_q);
  end

  // a register value of zero searches lane 0, above LANES searches all
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      active[j] = (lanes_q == 4'd0) ? (j == 0) : (j < int'(lanes_q));
      rd_sel[j] = (int'(lane_q) == j);
    end
  end

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    ffl_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .active_i (active[g]),
      .rd_sel_i (rd_sel[g]),
      .hit_i    (hit[g]),
      .hit_o    (hit[g+1]),
      .sel_o    (sel[g]),
      .stat_o   (stat[g])
    );
  end

  always_comb begin
    pick_lane  = '0;
    pick_count = '0;
    pick_full  = 1'b0;
    rd_count   = '0;
    rd_data    = '0;
    for (int j = 0; j < LANES; j++) begin
      if (sel[j]) begin
        pick_lane  = pick_lane | 3'(j);
        pick_count = pick_count | stat[j].count;
        pick_full  = pick_full | stat[j].full;
      end
      if (rd_sel[j]) begin
        rd_count = rd_count | stat[j].count;
        rd_data  = rd_data | stat[j].rdata;
      end
    end
  end

  // ----------------------------------------------------------------- result
  always_comb begin
    failed_d     = failed_q;
    res_status_d = ST_RANGE;
    res_lane_d   = '0;
    res_len_d    = '0;
    res_rd_d     = 1'b0;
    if (exec) begin
      case (act_q)
        ACT_PLACE: begin
          if (failed_q) begin
            res_status_d = ST_FAIL;
          end else if (!hit[LANES]) begin
            failed_d     = 1'b1;
            res_status_d = ST_FAIL;
          end else if (pick_full) begin
            res_status_d = ST_FULL;
            res_lane_d   = pick_lane;
            res_len_d    = 9'(pick_count);
          end else begin
            res_status_d = ST_PLACED;
            res_lane_d   = pick_lane;
            res_len_d    = 9'(pick_count + CNT_W'(1));
          end
        end
        ACT_READ: begin
          res_lane_d = lane_q;
          if (int'(lane_q) < LANES) begin
            res_len_d = 9'(rd_count);
            if (int'(pos_q) < int'(rd_count)) begin
              res_status_d = ST_READ_OK;
              res_rd_d     = 1'b1;
            end
          end
        end
        ACT_CLEAR: begin
          failed_d     = 1'b0;
          res_status_d = ST_PLACED;
        end
        default: res_status_d = ST_RANGE;
      endcase
    end
  end

  // ---------------------------------------------------------- output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_status_q;
      out_lane_q   <= res_lane_q;
      out_len_q    <= res_len_q;
      out_value_q  <= res_rd_q ? rd_data : 32'sd0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.chosen_lane = out_lane_q;
  assign out_o.read_value  = out_value_q;
  assign out_o.lane_length = out_len_q;

  // ------------------------------------------------------------- assertions
  // the claim row only carries a captured word during execute
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> $onehot0(sel))
    else $error("more than one lane cell claimed the value");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word appeared outside the done cycle");

  a_fail_from_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(failed_q) |-> $past(exec && (act_q == ACT_PLACE)))
    else $error("failed flag set without a place action");

  a_no_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> !in_i.ready)
    else $error("input word accepted during execute");

  a_exec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (state_q == S_DONE))
    else $error("execute cycle not followed by done");

endmodule
